@@ design/spq_pkg.sv @@
// Shared types, command and status codes for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   // Default number of entries the queue holds.
   localparam int DEPTH_DEFAULT = 16;

   // Command codes carried in the request beat.
   localparam logic [2:0] CMD_ENQUEUE        = 3'd0;
   localparam logic [2:0] CMD_DEQUEUE        = 3'd1;
   localparam logic [2:0] CMD_REMOVE_EXACT   = 3'd2;
   localparam logic [2:0] CMD_REMOVE_ATLEAST = 3'd3;
   localparam logic [2:0] CMD_CLEAR          = 3'd4;

   // Status codes carried in the response beat.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Request beat.
   typedef struct packed {
      logic [2:0]          cmd;
      logic [7:0]          priority_req;
      logic signed [31:0]  item_value;
   } spq_req_type;

   // Response beat.
   typedef struct packed {
      logic [1:0]          status;
      logic [7:0]          out_priority;
      logic signed [31:0]  out_value;
      logic [4:0]          entry_count;
   } spq_rsp_type;

   // Controller states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_COMPARE = 4'b0010,
      ST_SELECT  = 4'b0100,
      ST_UPDATE  = 4'b1000
   } spq_state_type;

   // Step commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic compare;
      logic select;
      logic update;
   } spq_ctl_type;

endpackage

@@ design/spq_controller.sv @@
// Sequencing state machine for the sorted priority queue.
`timescale 1ns / 1ps

module spq_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output spq_pkg::spq_ctl_type ctl
);
   import spq_pkg::*;

   spq_state_type state_ff, state_in;

   // Next-state logic: one pass of compare, select and update per command.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_COMPARE;
         end
         ST_COMPARE: state_in = ST_SELECT;
         ST_SELECT:  state_in = ST_UPDATE;
         ST_UPDATE:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Step commands and the busy flag.
   always_comb begin
      busy        = (state_ff != ST_IDLE);
      ctl.load    = (state_ff == ST_IDLE) && start;
      ctl.compare = (state_ff == ST_COMPARE);
      ctl.select  = (state_ff == ST_SELECT);
      ctl.update  = (state_ff == ST_UPDATE);
   end

endmodule

@@ design/spq_datapath.sv @@
// Sorted slot array with per-slot compare, match select and shift logic.
`timescale 1ns / 1ps

module spq_datapath #(
   parameter int Depth = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spq_pkg::spq_ctl_type ctl,
   input  spq_pkg::spq_req_type req_data,
   output logic                 rsp_strobe,
   output spq_pkg::spq_rsp_type rsp_data
);
   import spq_pkg::*;

   localparam int CountW = $clog2(Depth + 1);

   // Captured command.
   spq_req_type         op_ff;

   // Slot storage; only slots marked valid are ever read out.
   logic [7:0]          pri_ff [Depth];
   logic signed [31:0]  val_ff [Depth];
   logic [Depth-1:0]    valid_ff, valid_in;
   logic [CountW-1:0]   count_ff, count_in;

   // Compare and select results.
   logic [Depth-1:0]    region_ff, region_in;
   logic [Depth-1:0]    eq_ff, eq_in;
   logic [Depth-1:0]    first;
   logic [Depth-1:0]    open;
   logic                found_ff, found_in;
   logic                full_ff;
   logic [7:0]          sel_pri_ff, sel_pri_in;
   logic signed [31:0]  sel_val_ff, sel_val_in;

   // Response register.
   spq_rsp_type         rsp_ff, rsp_in;
   logic                strobe_ff;

   // Capture the request beat.
   always_ff @(posedge clock) begin
      if (ctl.load) op_ff <= req_data;
   end

   // Per-slot compares. The region is the run of slots that move: it is a
   // suffix of the valid prefix because the slots are sorted.
   always_comb begin
      for (int i = 0; i < Depth; i++) begin
         eq_in[i] = valid_ff[i] && (pri_ff[i] == op_ff.priority_req);
         case (op_ff.cmd)
            CMD_ENQUEUE:     region_in[i] = valid_ff[i] && (pri_ff[i] > op_ff.priority_req);
            CMD_DEQUEUE:     region_in[i] = valid_ff[i];
            CMD_REMOVE_EXACT,
            CMD_REMOVE_ATLEAST:
                             region_in[i] = valid_ff[i] && (pri_ff[i] >= op_ff.priority_req);
            default:         region_in[i] = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.compare) begin
         region_ff <= region_in;
         eq_ff     <= eq_in;
      end
   end

   // The first slot of the region is the removal candidate.
   assign first = region_ff & ~{region_ff[Depth-2:0], 1'b0};
   // Slots at or past the insertion point.
   assign open  = region_ff | ~valid_ff;

   // One-hot select of the candidate entry.
   always_comb begin
      found_in   = 1'b0;
      sel_pri_in = '0;
      sel_val_in = '0;
      for (int i = 0; i < Depth; i++) begin
         if (first[i] && ((op_ff.cmd != CMD_REMOVE_EXACT) || eq_ff[i])) begin
            found_in   = 1'b1;
            sel_pri_in = sel_pri_in | pri_ff[i];
            sel_val_in = sel_val_in | val_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.select) begin
         found_ff   <= found_in;
         full_ff    <= valid_ff[Depth-1];
         sel_pri_ff <= sel_pri_in;
         sel_val_ff <= sel_val_in;
      end
   end

   // Slot cells: shift right on insert, shift left on removal.
   for (genvar g = 0; g < Depth; g++) begin : g_slot
      logic        take_prev, take_new, take_next;
      logic [7:0]  prev_pri, next_pri;
      logic signed [31:0] prev_val, next_val;

      if (g == 0) begin : g_head
         assign take_prev = 1'b0;
         assign prev_pri  = '0;
         assign prev_val  = '0;
      end else begin : g_body
         assign take_prev = open[g-1];
         assign prev_pri  = pri_ff[g-1];
         assign prev_val  = val_ff[g-1];
      end

      if (g == Depth - 1) begin : g_tail
         assign take_next = 1'b0;
         assign next_pri  = '0;
         assign next_val  = '0;
      end else begin : g_inner
         assign take_next = region_ff[g];
         assign next_pri  = pri_ff[g+1];
         assign next_val  = val_ff[g+1];
      end

      assign take_new = open[g];

      always_ff @(posedge clock) begin
         if (ctl.update) begin
            case (op_ff.cmd)
               CMD_ENQUEUE: begin
                  if (!full_ff) begin
                     if (take_prev) begin
                        pri_ff[g] <= prev_pri;
                        val_ff[g] <= prev_val;
                     end else if (take_new) begin
                        pri_ff[g] <= op_ff.priority_req;
                        val_ff[g] <= op_ff.item_value;
                     end
                  end
               end
               CMD_DEQUEUE, CMD_REMOVE_EXACT, CMD_REMOVE_ATLEAST: begin
                  if (found_ff && take_next) begin
                     pri_ff[g] <= next_pri;
                     val_ff[g] <= next_val;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Occupancy and response for the update step.
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      rsp_in.status       = STATUS_OK;
      rsp_in.out_priority = '0;
      rsp_in.out_value    = '0;
      case (op_ff.cmd)
         CMD_ENQUEUE: begin
            if (full_ff) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               valid_in            = {valid_ff[Depth-2:0], 1'b1};
               count_in            = count_ff + 1'b1;
               rsp_in.out_priority = op_ff.priority_req;
               rsp_in.out_value    = op_ff.item_value;
            end
         end
         CMD_DEQUEUE, CMD_REMOVE_EXACT, CMD_REMOVE_ATLEAST: begin
            if (found_ff) begin
               valid_in            = {1'b0, valid_ff[Depth-1:1]};
               count_in            = count_ff - 1'b1;
               rsp_in.out_priority = sel_pri_ff;
               rsp_in.out_value    = sel_val_ff;
            end else begin
               rsp_in.status = STATUS_EMPTY;
            end
         end
         CMD_CLEAR: begin
            valid_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
      rsp_in.entry_count = 5'(count_in);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl.update;
         if (ctl.update) begin
            valid_ff <= valid_in;
            count_ff <= count_in;
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (ctl.update) rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ design/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: controller plus slot datapath.
`timescale 1ns / 1ps
// The response beat is registered after the update step; busy is high for the compare, select and
// update steps, so the block takes no new command until the current one is through, and the next
// command may start in the cycle the response is shown.
// The response is held for exactly one cycle and the receiver cannot stall it.
// Reset (synchronous, active high) empties the queue and returns to idle at once.

module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  spq_pkg::spq_req_type req_data,
   output logic                 rsp_strobe,
   output spq_pkg::spq_rsp_type rsp_data
);
   import spq_pkg::*;

   spq_ctl_type ctl;

   // Step sequencer.
   spq_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctl   (ctl)
   );

   // Sorted slot storage and match logic.
   spq_datapath #(
      .Depth (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ design/spq_checker.sv @@
// Port-level checks for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps

module spq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input spq_pkg::spq_rsp_type rsp_data
);
   import spq_pkg::*;

   // An accepted command makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted command");

   // Every accepted command yields its response beat once its update step is done.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("response beat missing after an accepted command");

   // A response beat lasts one cycle only.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held longer than one cycle");

   // The status is one of the defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_EMPTY ||
                      rsp_data.status == STATUS_FULL))
      else $error("undefined status code");

   // A refused or unmatched command carries no entry.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != STATUS_OK) |->
         (rsp_data.out_priority == 8'd0 && rsp_data.out_value == 32'sd0))
      else $error("entry returned with a failing status");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

@@ sim/tb_sorted_priority_queue.sv @@
// Self-checking testbench for the sorted priority queue: directed table, then random commands.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
   localparam int RANDOM_COMMANDS = 830;
   localparam int DRAIN_INTERVAL = 200;
   localparam int QUIET_TAIL = 100;
   localparam int SETTLE_CYCLES = 10;
   localparam int MAX_REPORTS = 40;

   // Command codes the block ignores.
   localparam logic [2:0] CMD_RESERVED_LO = 3'd5;
   localparam logic [2:0] CMD_RESERVED_HI = 3'd7;

   // Random command mixes: grow the queue, shrink it, or hold it level.
   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_LEVEL
   } mix_type;

   // One row of the directed table.
   typedef struct {
      spq_req_type req;
      bit          fixed;
      spq_rsp_type rsp;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   spq_req_type req_data;
   logic        rsp_strobe;
   spq_rsp_type rsp_data;

   // Mirror of the queue contents, kept sorted with the head in slot 0.
   logic [7:0]  mirror_priority [QUEUE_DEPTH];
   logic [31:0] mirror_value [QUEUE_DEPTH];
   int          mirror_count;

   spq_rsp_type      awaited_rsp [$];
   directed_row_type directed_rows [$];

   int error_count;
   int commands_sent;
   int responses_seen;
   int full_refusals;
   int empty_misses;
   int peak_count;

   sorted_priority_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Apply one command to the mirror and return the response it must produce.
   function automatic spq_rsp_type apply_queue_command(spq_req_type req);
      spq_rsp_type rsp;
      int          pos;
      int          i;
      bit          found;
      bit          hit;
      rsp = '0;
      rsp.status = STATUS_OK;
      case (req.cmd)
         CMD_ENQUEUE: begin
            if (mirror_count >= QUEUE_DEPTH) begin
               rsp.status = STATUS_FULL;
            end else begin
               // A new entry goes behind every entry of equal priority.
               pos = mirror_count;
               for (i = 0; i < mirror_count; i++) begin
                  if (mirror_priority[i] > req.priority_req) begin
                     pos = i;
                     break;
                  end
               end
               for (i = mirror_count; i > pos; i--) begin
                  mirror_priority[i] = mirror_priority[i - 1];
                  mirror_value[i] = mirror_value[i - 1];
               end
               mirror_priority[pos] = req.priority_req;
               mirror_value[pos] = req.item_value;
               mirror_count++;
               rsp.out_priority = req.priority_req;
               rsp.out_value = req.item_value;
            end
         end
         CMD_DEQUEUE, CMD_REMOVE_EXACT, CMD_REMOVE_ATLEAST: begin
            // Take the first entry from the head that satisfies the command.
            found = 1'b0;
            pos = 0;
            for (i = 0; i < mirror_count; i++) begin
               hit = (req.cmd == CMD_DEQUEUE) ||
                     (req.cmd == CMD_REMOVE_EXACT && mirror_priority[i] == req.priority_req) ||
                     (req.cmd == CMD_REMOVE_ATLEAST && mirror_priority[i] >= req.priority_req);
               if (hit) begin
                  pos = i;
                  found = 1'b1;
                  break;
               end
            end
            if (found) begin
               rsp.out_priority = mirror_priority[pos];
               rsp.out_value = mirror_value[pos];
               for (i = pos; i + 1 < mirror_count; i++) begin
                  mirror_priority[i] = mirror_priority[i + 1];
                  mirror_value[i] = mirror_value[i + 1];
               end
               mirror_count--;
            end else begin
               rsp.status = STATUS_EMPTY;
            end
         end
         CMD_CLEAR: begin
            mirror_count = 0;
         end
         default: begin
            // Unused codes leave the queue alone.
         end
      endcase
      rsp.entry_count = 5'(mirror_count);
      return rsp;
   endfunction

   function automatic void add_row(logic [2:0] cmd, logic [7:0] prio, logic [31:0] value,
                                   bit fixed, logic [1:0] status = STATUS_OK,
                                   logic [7:0] out_prio = '0, logic [31:0] out_value = '0,
                                   logic [4:0] count = '0);
      directed_row_type row;
      row.req.cmd = cmd;
      row.req.priority_req = prio;
      row.req.item_value = value;
      row.fixed = fixed;
      row.rsp.status = status;
      row.rsp.out_priority = out_prio;
      row.rsp.out_value = out_value;
      row.rsp.entry_count = count;
      directed_rows.push_back(row);
   endfunction

   // Random command with a mix-dependent share of enqueues.
   function automatic spq_req_type random_command(mix_type mix);
      spq_req_type req;
      int          pick;
      int          enqueue_share;
      case (mix)
         MIX_FILL:  enqueue_share = 70;
         MIX_DRAIN: enqueue_share = 25;
         default:   enqueue_share = 48;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < enqueue_share) begin
         req.cmd = CMD_ENQUEUE;
      end else if (pick < 96) begin
         case ($urandom_range(0, 2))
            0:       req.cmd = CMD_DEQUEUE;
            1:       req.cmd = CMD_REMOVE_EXACT;
            default: req.cmd = CMD_REMOVE_ATLEAST;
         endcase
      end else if (pick < 99) begin
         req.cmd = 3'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
      end else begin
         req.cmd = CMD_CLEAR;
      end
      // Crowd priorities together so that ties and exact hits are common.
      case ($urandom_range(0, 3))
         0:       req.priority_req = 8'($urandom_range(0, 255));
         1:       req.priority_req = 8'($urandom_range(0, 3));
         2:       req.priority_req = 8'($urandom_range(252, 255));
         default: begin
            if (mirror_count > 0) begin
               req.priority_req = mirror_priority[$urandom_range(0, mirror_count - 1)];
            end else begin
               req.priority_req = 8'($urandom_range(0, 255));
            end
         end
      endcase
      req.item_value = $urandom;
      return req;
   endfunction

   // Present one command beat and hold it until the block takes it.
   task automatic send_command(spq_req_type req, bit fixed, spq_rsp_type fixed_rsp);
      spq_rsp_type predicted;
      req_data <= req;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = apply_queue_command(req);
      awaited_rsp.push_back(fixed ? fixed_rsp : predicted);
      commands_sent++;
      if (predicted.status == STATUS_FULL) full_refusals++;
      if (predicted.status == STATUS_EMPTY) empty_misses++;
      if (mirror_count > peak_count) peak_count = mirror_count;
   endtask

   task automatic report_mismatch(string field, logic [31:0] expected_bits,
                                  logic [31:0] actual_bits);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field,
                  expected_bits, actual_bits);
      end
   endtask

   // Compare every response beat with the oldest outstanding expectation.
   always @(posedge clock) begin
      spq_rsp_type expected_rsp;
      if (!reset && rsp_strobe) begin
         responses_seen++;
         if (awaited_rsp.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("%0t: response with no command outstanding, expected none, actual %h",
                        $time, rsp_data);
            end
         end else begin
            expected_rsp = awaited_rsp.pop_front();
            if (rsp_data.status !== expected_rsp.status)
               report_mismatch("status", 32'(expected_rsp.status), 32'(rsp_data.status));
            if (rsp_data.out_priority !== expected_rsp.out_priority)
               report_mismatch("out_priority", 32'(expected_rsp.out_priority),
                               32'(rsp_data.out_priority));
            if (rsp_data.out_value !== expected_rsp.out_value)
               report_mismatch("out_value", expected_rsp.out_value, rsp_data.out_value);
            if (rsp_data.entry_count !== expected_rsp.entry_count)
               report_mismatch("entry_count", 32'(expected_rsp.entry_count),
                               32'(rsp_data.entry_count));
         end
      end
   end

   // Main sequence: reset, directed table, random commands, drain.
   initial begin
      spq_req_type req;
      spq_rsp_type unused_rsp;
      mix_type     mix;
      int          gap;
      bit          drain_now;
      bit          quiet;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      unused_rsp = '0;
      mix = MIX_FILL;
      error_count = 0;
      commands_sent = 0;
      responses_seen = 0;
      full_refusals = 0;
      empty_misses = 0;
      peak_count = 0;
      mirror_count = 0;
      foreach (mirror_priority[i]) begin
         mirror_priority[i] = '0;
         mirror_value[i] = '0;
      end

      // Removals from an empty queue, extreme entries, ties, misses and unused codes.
      add_row(CMD_DEQUEUE, 8'h00, 32'h0, 1'b1, STATUS_EMPTY, 8'h00, 32'h0, 5'd0);
      add_row(CMD_REMOVE_EXACT, 8'h00, 32'h0, 1'b1, STATUS_EMPTY, 8'h00, 32'h0, 5'd0);
      add_row(CMD_REMOVE_ATLEAST, 8'h00, 32'h0, 1'b1, STATUS_EMPTY, 8'h00, 32'h0, 5'd0);
      add_row(CMD_ENQUEUE, 8'h00, 32'h8000_0000, 1'b1, STATUS_OK, 8'h00, 32'h8000_0000, 5'd1);
      add_row(CMD_ENQUEUE, 8'hFF, 32'h7FFF_FFFF, 1'b1, STATUS_OK, 8'hFF, 32'h7FFF_FFFF, 5'd2);
      add_row(CMD_ENQUEUE, 8'h00, 32'hFFFF_FFFF, 1'b0);
      add_row(CMD_REMOVE_EXACT, 8'h00, 32'h0, 1'b0);
      add_row(CMD_REMOVE_ATLEAST, 8'h80, 32'h0, 1'b0);
      add_row(CMD_REMOVE_EXACT, 8'hAA, 32'h0, 1'b0);
      add_row(CMD_RESERVED_LO, 8'hFF, 32'hFFFF_FFFF, 1'b0);
      add_row(CMD_RESERVED_HI, 8'h55, 32'h5555_5555, 1'b0);
      add_row(CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF, 1'b1, STATUS_OK, 8'h00, 32'h0, 5'd0);
      // Fill with falling priorities so that every entry lands at the head.
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         add_row(CMD_ENQUEUE, 8'(255 - i * 17), 32'(i) ^ 32'hA5A5_0000, 1'b0);
      end
      add_row(CMD_ENQUEUE, 8'h40, 32'h1234_5678, 1'b1, STATUS_FULL, 8'h00, 32'h0,
              5'(QUEUE_DEPTH));
      add_row(CMD_CLEAR, 8'h00, 32'h0, 1'b1, STATUS_OK, 8'h00, 32'h0, 5'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table, back to back.
      foreach (directed_rows[i]) begin
         send_command(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);
      end
      start <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);

      // Random commands with bursts of idle cycles on the request side.
      for (int n = 0; n < RANDOM_COMMANDS; n++) begin
         if (n % 40 == 0) mix = mix_type'($urandom_range(0, 2));
         req = random_command(mix);
         send_command(req, 1'b0, unused_rsp);
         quiet = (n >= RANDOM_COMMANDS - QUIET_TAIL) || (n >= 300 && n < 360);
         drain_now = (n % DRAIN_INTERVAL == DRAIN_INTERVAL - 1) && !quiet;
         gap = (!quiet && $urandom_range(0, 9) < 3) ? $urandom_range(1, 14) : 0;
         if (drain_now || gap > 0) start <= 1'b0;
         // Hold off until every outstanding response has come back.
         if (drain_now) begin
            while (awaited_rsp.size() != 0) @(posedge clock);
         end
         repeat (gap) @(posedge clock);
      end
      start <= 1'b0;

      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d commands and checked %0d responses; peak occupancy %0d of %0d.",
               commands_sent, responses_seen, peak_count, QUEUE_DEPTH);
      $display("Refused enqueues on a full queue: %0d; removals that found nothing: %0d.",
               full_refusals, empty_misses);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop in case the block stops responding.
   initial begin
      #2_000_000;
      $display("Timeout: the run did not finish in time.");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
